// ===== src/wfw_pkg.sv =====
`timescale 1ns / 1ps

package wfw_pkg;

   typedef struct packed {
      logic [15:0] word_id;
      logic        batch_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weight;
      logic               run_last;
   } rsp_type;

   typedef struct packed {
      logic               mode;
      logic [31:0]        count_threshold;
      logic signed [31:0] exp_scale;
      logic signed [31:0] exp_rate;
      logic signed [31:0] lin_slope;
      logic signed [31:0] lin_offset;
   } cfg_type;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_RATE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIN_SLOPE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIN_OFFSET = 3'd5;

   localparam logic signed [31:0] WEIGHT_ONE = 32'sd65536;
   localparam logic signed [31:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] WEIGHT_MIN = 32'sh8000_0000;

   // Counts are widened to this many bits and multiplied in two 24-bit halves.
   localparam int CNT_EXT_W = 48;
   localparam int CNT_HALF_W = 24;

   localparam logic [35:0] LN2_Q30 = 36'd744261118;

   typedef struct packed {
      logic clr_en;
      logic accept;
      logic update;
      logic w_start;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic last_item;
      logic fill_zero;
      logic idx_last;
      logic w_done;
      logic rsp_busy;
   } sts_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_UPDATE,
      S_RO_CHECK,
      S_RO_BUF,
      S_RO_CNT,
      S_RO_START,
      S_RO_WAIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      W_IDLE,
      W_MUL0,
      W_MUL1,
      W_SELECT,
      W_DIVIDE,
      W_REMAIN,
      W_CORRECT,
      W_REDUCE,
      W_POLY,
      W_SCALE,
      W_SHIFT
   } wgt_state_type;

   // round(2^30 / n!)
   function automatic logic [31:0] inv_fact(input logic [3:0] n);
      logic [31:0] v;
      case (n)
         4'd0:    v = 32'd1073741824;
         4'd1:    v = 32'd1073741824;
         4'd2:    v = 32'd536870912;
         4'd3:    v = 32'd178956971;
         4'd4:    v = 32'd44739243;
         4'd5:    v = 32'd8947849;
         4'd6:    v = 32'd1491308;
         4'd7:    v = 32'd213044;
         4'd8:    v = 32'd26631;
         4'd9:    v = 32'd2959;
         4'd10:   v = 32'd296;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/wfw_ram.sv =====
`timescale 1ns / 1ps

module wfw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/wfw_weight.sv =====
`timescale 1ns / 1ps

module wfw_weight import wfw_pkg::*; #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [COUNT_WIDTH-1:0] count,
   input  cfg_type                cfg,
   output logic                   done,
   output logic signed [31:0]     result
);

   localparam logic [80:0] ACC_LIN_LIM = 81'd1 << 41;
   localparam logic [80:0] ACC_EXP_LIM = 81'd1 << 29;
   localparam logic signed [45:0] LIN_MAX = 46'sd2147483647;
   localparam logic signed [45:0] LIN_MIN = -46'sd2147483648;
   // floor(2^36 / LN2_Q30): quotient estimate is low by at most one
   localparam logic [31:0] RECIP_LN2 = 32'd92;

   wgt_state_type state_ff, state_in;
   logic [CNT_EXT_W-1:0] c_ff, c_in;
   logic lin_ff, lin_in;
   logic neg_ff, neg_in;
   logic [31:0] opd_ff, opd_in;
   logic [80:0] acc_ff, acc_in;
   logic [35:0] rem_ff, rem_in;
   logic [5:0] q_ff, q_in;
   logic [3:0] step_ff, step_in;
   logic signed [7:0] k_ff, k_in;
   logic [29:0] r_ff, r_in;
   logic [31:0] p_ff, p_in;
   logic [63:0] prod_ff, prod_in;
   logic signed [31:0] res_ff, res_in;
   logic done_ff, done_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [31:0] sel_opd;
   logic [31:0] scale_mag;
   logic [29:0] xm;
   logic signed [31:0] lin_res;
   logic signed [31:0] exp_res;

   assign mul_p = mul_a * mul_b;
   assign scale_mag = cfg.exp_scale[31] ? 32'(-cfg.exp_scale) : cfg.exp_scale;
   assign xm = (acc_ff > ACC_EXP_LIM) ? 30'h2000_0000 : acc_ff[29:0];

   // Linear weight: exact Q24 sum, round half up to Q16, saturate.
   always_comb begin
      logic signed [45:0] a;
      logic signed [45:0] v;
      logic signed [45:0] q;
      a = $signed({4'b0, acc_ff[41:0]});
      v = (neg_ff ? -a : a) + $signed({{6{cfg.lin_offset[31]}}, cfg.lin_offset, 8'b0})
          + 46'sd128;
      q = v >>> 8;
      if (acc_ff > ACC_LIN_LIM) begin
         lin_res = neg_ff ? WEIGHT_MIN : WEIGHT_MAX;
      end else if (q > LIN_MAX) begin
         lin_res = WEIGHT_MAX;
      end else if (q < LIN_MIN) begin
         lin_res = WEIGHT_MIN;
      end else begin
         lin_res = 32'(q);
      end
   end

   // Exponential weight: scale by 2^k with rounding, saturate toward the scale sign.
   always_comb begin
      logic signed [7:0] s;
      logic [63:0] lim;
      logic [63:0] q;
      logic [4:0] ls;
      logic [5:0] sh;
      s = 8'sd30 - k_ff;
      lim = cfg.exp_scale[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      ls = 5'(-s);
      sh = 6'(s);
      if (s <= 8'sd0) begin
         q = (prod_ff > (lim >> ls)) ? lim : (prod_ff << ls);
      end else if (s >= 8'sd64) begin
         q = 64'd0;
      end else begin
         q = (prod_ff + (64'd1 << (sh - 6'd1))) >> sh;
      end
      if (q > lim) begin
         q = lim;
      end
      exp_res = cfg.exp_scale[31] ? 32'(-q) : 32'(q);
   end

   always_comb begin
      state_in = state_ff;
      c_in = c_ff;
      lin_in = lin_ff;
      neg_in = neg_ff;
      opd_in = opd_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      step_in = step_ff;
      k_in = k_ff;
      r_in = r_ff;
      p_in = p_ff;
      prod_in = prod_ff;
      res_in = res_ff;
      done_in = done_ff;
      mul_a = opd_ff;
      mul_b = {8'b0, c_ff[CNT_HALF_W-1:0]};
      sel_opd = 32'd0;
      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               c_in = CNT_EXT_W'(count);
               done_in = 1'b0;
               if (!cfg.mode) begin
                  res_in = WEIGHT_ONE;
                  done_in = 1'b1;
               end else begin
                  lin_in = CNT_EXT_W'(count) > CNT_EXT_W'(cfg.count_threshold);
                  sel_opd = lin_in ? cfg.lin_slope : cfg.exp_rate;
                  neg_in = sel_opd[31];
                  opd_in = sel_opd[31] ? 32'(-sel_opd) : sel_opd;
                  state_in = W_MUL0;
               end
            end
         end
         W_MUL0: begin
            acc_in = 81'(mul_p);
            state_in = W_MUL1;
         end
         W_MUL1: begin
            mul_b = {8'b0, c_ff[CNT_EXT_W-1:CNT_HALF_W]};
            acc_in = acc_ff + 81'({mul_p, 24'b0});
            state_in = W_SELECT;
         end
         W_SELECT: begin
            if (lin_ff) begin
               res_in = lin_res;
               done_in = 1'b1;
               state_in = W_IDLE;
            end else begin
               rem_in = {xm, 6'b0};
               state_in = W_DIVIDE;
            end
         end
         W_DIVIDE: begin
            // estimate the quotient by reciprocal multiplication
            mul_a = {2'b0, xm};
            mul_b = RECIP_LN2;
            q_in = mul_p[35:30];
            state_in = W_REMAIN;
         end
         W_REMAIN: begin
            mul_a = {26'b0, q_ff};
            mul_b = LN2_Q30[31:0];
            rem_in = rem_ff - mul_p[35:0];
            state_in = W_CORRECT;
         end
         W_CORRECT: begin
            // advance the estimate once if the remainder still holds a full LN2
            if (rem_ff >= LN2_Q30) begin
               rem_in = rem_ff - LN2_Q30;
               q_in = q_ff + 6'd1;
            end
            state_in = W_REDUCE;
         end
         W_REDUCE: begin
            // floor division for negative arguments
            if (!neg_ff) begin
               k_in = $signed({2'b0, q_ff});
               r_in = rem_ff[29:0];
            end else if (rem_ff != 36'd0) begin
               k_in = -($signed({2'b0, q_ff}) + 8'sd1);
               r_in = 30'(LN2_Q30 - rem_ff);
            end else begin
               k_in = -$signed({2'b0, q_ff});
               r_in = 30'd0;
            end
            p_in = inv_fact(4'd10);
            step_in = 4'd9;
            state_in = W_POLY;
         end
         W_POLY: begin
            mul_a = p_ff;
            mul_b = {2'b0, r_ff};
            p_in = inv_fact(step_ff) + mul_p[61:30];
            if (step_ff == 4'd0) begin
               state_in = W_SCALE;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         W_SCALE: begin
            mul_a = scale_mag;
            mul_b = p_ff;
            prod_in = mul_p;
            state_in = W_SHIFT;
         end
         W_SHIFT: begin
            res_in = exp_res;
            done_in = 1'b1;
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      c_ff <= c_in;
      lin_ff <= lin_in;
      neg_ff <= neg_in;
      opd_ff <= opd_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      step_ff <= step_in;
      k_ff <= k_in;
      r_ff <= r_in;
      p_ff <= p_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

// ===== src/wfw_datapath.sv =====
`timescale 1ns / 1ps

module wfw_datapath import wfw_pkg::*; #(
   parameter int VOCAB_SIZE = 65536,
   parameter int MAX_BATCH = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int VA = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
   localparam int BA = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
   localparam int FW = $clog2(MAX_BATCH + 1);

   cfg_type cfg_ff, cfg_in;
   logic [VA-1:0] clr_addr_ff, clr_addr_in;
   logic [VA-1:0] waddr_ff, waddr_in;
   logic inr_ff, inr_in;
   logic drop_ff, drop_in;
   logic last_ff, last_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [BA-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic cnt_we;
   logic [VA-1:0] cnt_waddr, cnt_raddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata, cnt_inc;
   logic [15:0] buf_rdata;
   logic req_inr, buf_inr;
   logic w_done;
   logic signed [31:0] w_result;
   logic [COUNT_WIDTH-1:0] w_count;

   assign req_inr = {16'b0, req_data.word_id} < 32'(VOCAB_SIZE);
   assign buf_inr = {16'b0, buf_rdata} < 32'(VOCAB_SIZE);
   assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);

   assign cnt_we = cmd.clr_en | (cmd.update & inr_ff & ~drop_ff);
   assign cnt_waddr = cmd.clr_en ? clr_addr_ff : waddr_ff;
   assign cnt_wdata = cmd.clr_en ? '0 : cnt_inc;
   assign cnt_raddr = cmd.accept ? VA'(req_data.word_id) : VA'(buf_rdata);

   wfw_ram #(
      .WIDTH(COUNT_WIDTH),
      .DEPTH(VOCAB_SIZE)
   ) u_counts (
      .clock(clock),
      .wr_en(cnt_we),
      .wr_addr(cnt_waddr),
      .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr),
      .rd_data(cnt_rdata)
   );

   wfw_ram #(
      .WIDTH(16),
      .DEPTH(MAX_BATCH)
   ) u_words (
      .clock(clock),
      .wr_en(cmd.accept & (fill_ff != FW'(MAX_BATCH))),
      .wr_addr(BA'(fill_ff)),
      .wr_data(req_data.word_id),
      .rd_addr(idx_ff),
      .rd_data(buf_rdata)
   );

   assign w_count = buf_inr ? cnt_rdata : '0;

   wfw_weight #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_weight (
      .clock(clock),
      .reset(reset),
      .start(cmd.w_start),
      .count(w_count),
      .cfg(cfg_ff),
      .done(w_done),
      .result(w_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      clr_addr_in = clr_addr_ff;
      waddr_in = waddr_ff;
      inr_in = inr_ff;
      drop_in = drop_ff;
      last_in = last_ff;
      fill_in = fill_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in = rsp_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:       cfg_in.mode = csr_data[0];
            CSR_THRESHOLD:  cfg_in.count_threshold = csr_data;
            CSR_EXP_SCALE:  cfg_in.exp_scale = csr_data;
            CSR_EXP_RATE:   cfg_in.exp_rate = csr_data;
            CSR_LIN_SLOPE:  cfg_in.lin_slope = csr_data;
            CSR_LIN_OFFSET: cfg_in.lin_offset = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
      if (cmd.clr_en) begin
         clr_addr_in = clr_addr_ff + VA'(1);
      end
      if (cmd.accept) begin
         waddr_in = VA'(req_data.word_id);
         inr_in = req_inr;
         drop_in = fill_ff == FW'(MAX_BATCH);
         last_in = req_data.batch_end;
      end
      if (cmd.update & ~drop_ff) begin
         fill_in = fill_ff + FW'(1);
      end
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         rsp_in.weight = w_result;
         rsp_in.run_last = sts.idx_last;
         if (sts.idx_last) begin
            idx_in = '0;
            fill_in = '0;
         end else begin
            idx_in = idx_ff + BA'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= 1'b0;
         cfg_ff.count_threshold <= 32'd0;
         cfg_ff.exp_scale <= WEIGHT_ONE;
         cfg_ff.exp_rate <= 32'sd0;
         cfg_ff.lin_slope <= 32'sd0;
         cfg_ff.lin_offset <= WEIGHT_ONE;
         clr_addr_ff <= '0;
         fill_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff <= 1'b0;
         drop_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         clr_addr_ff <= clr_addr_in;
         fill_ff <= fill_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff <= last_in;
         drop_ff <= drop_in;
      end
      waddr_ff <= waddr_in;
      inr_ff <= inr_in;
      rsp_ff <= rsp_in;
   end

   assign sts.clr_last = clr_addr_ff == VA'(VOCAB_SIZE - 1);
   assign sts.last_item = last_ff;
   assign sts.fill_zero = fill_ff == '0;
   assign sts.idx_last = (FW'(idx_ff) + FW'(1)) == fill_ff;
   assign sts.w_done = w_done;
   assign sts.rsp_busy = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== src/wfw_ctrl.sv =====
`timescale 1ns / 1ps

module wfw_ctrl import wfw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in = sts.last_item ? S_RO_CHECK : S_IDLE;
         end
         S_RO_CHECK: begin
            state_in = sts.fill_zero ? S_IDLE : S_RO_BUF;
         end
         S_RO_BUF: begin
            state_in = S_RO_CNT;
         end
         S_RO_CNT: begin
            state_in = S_RO_START;
         end
         S_RO_START: begin
            cmd.w_start = 1'b1;
            state_in = S_RO_WAIT;
         end
         S_RO_WAIT: begin
            if (sts.w_done && !sts.rsp_busy) begin
               cmd.push = 1'b1;
               state_in = sts.idx_last ? S_IDLE : S_RO_BUF;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/word_frequency_weighting.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_data   (word_id, batch_end)
// rsp      out        rsp_valid/rsp_ready   rsp_data   (weight, run_last)
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// Each request is a histogram read, then a saturating write-back.
// On a batch_end request a check state follows, then each buffered word is weighted
// in turn. In mode 1 the weight unit uses the shared 32x32 multiplier (two count
// halves, then ten Horner steps and one scale product in the exponential range) and
// there a range reduction (reciprocal estimate, remainder, one correction).
// After reset a clearing pass writes zero to all VOCAB_SIZE histogram
// entries, one per cycle; no request is taken until it ends.
// A stalled response holds in the output register; readout of the next word
// waits for it, while csr writes are taken in every cycle.

module word_frequency_weighting import wfw_pkg::*; #(
   parameter int VOCAB_SIZE = 65536,
   parameter int MAX_BATCH = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cmd_type cmd;
   sts_type sts;

   // Registers accept a write in any cycle.
   assign csr_ready = 1'b1;

   // Sequence requests, readout and the clearing pass.
   wfw_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts(sts),
      .cmd(cmd)
   );

   // Histogram, word buffer, weight unit and response register.
   wfw_datapath #(
      .VOCAB_SIZE(VOCAB_SIZE),
      .MAX_BATCH(MAX_BATCH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid & csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

endmodule

// ===== src/wfw_checker.sv =====
`timescale 1ns / 1ps

module wfw_checker import wfw_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsp_type              rsp_data,
   input logic                 csr_ready
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   a_rsp_not_during_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised while requests were open");

   a_csr_open: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register write port not ready");

endmodule

bind word_frequency_weighting wfw_checker u_checker (.*);
